>>> hw/rtl/skt_pkg.sv
// Types and constants shared by the sorted key table modules.
package skt_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned YEAR_W = 16;
  localparam int unsigned RANK_W = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_RANK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_UPD
  } fsm_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
interface skt_req_if;
  logic                             valid;
  logic                             ready;
  skt_pkg::req_type_e               req_type;
  logic signed [skt_pkg::KEY_W-1:0] key;
  logic [skt_pkg::YEAR_W-1:0]       year_in;

  modport source (output valid, output req_type, output key, output year_in, input ready);
  modport sink   (input valid, input req_type, input key, input year_in, output ready);
endinterface

interface skt_rsp_if;
  logic                       valid;
  logic                       ready;
  skt_pkg::status_e           status;
  logic [skt_pkg::YEAR_W-1:0] year_out;
  logic [skt_pkg::RANK_W-1:0] rank;

  modport source (output valid, output status, output year_out, output rank, input ready);
  modport sink   (input valid, input status, input year_out, input rank, output ready);
endinterface

>>> hw/rtl/skt_cell.sv
// One cell of the sorted chain: holds a record, compares it and shifts it.
module skt_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  skt_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occ_i,
  input  logic                              prev_less_i,
  input  logic signed [skt_pkg::KEY_W-1:0]  req_key_i,
  input  logic [skt_pkg::YEAR_W-1:0]        req_year_i,
  input  logic signed [skt_pkg::KEY_W-1:0]  left_key_i,
  input  logic [skt_pkg::YEAR_W-1:0]        left_year_i,
  input  logic signed [skt_pkg::KEY_W-1:0]  right_key_i,
  input  logic [skt_pkg::YEAR_W-1:0]        right_year_i,
  output logic signed [skt_pkg::KEY_W-1:0]  key_o,
  output logic [skt_pkg::YEAR_W-1:0]        year_o,
  output logic                              less_o,
  output logic                              eq_o
);
  import skt_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic [YEAR_W-1:0]       year_q, year_d;
  logic                    less_q, less_d;
  logic                    eq_q, eq_d;

  always_comb begin
    less_d = less_q;
    eq_d   = eq_q;
    if (ctrl_i.cmp_en) begin
      less_d = occ_i && (key_q < req_key_i);
      eq_d   = occ_i && (key_q == req_key_i);
    end
  end

  always_comb begin
    key_d  = key_q;
    year_d = year_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!less_q) begin
          if (prev_less_i) begin
            key_d  = req_key_i;
            year_d = req_year_i;
          end else begin
            key_d  = left_key_i;
            year_d = left_year_i;
          end
        end
      end
      OP_REMOVE: begin
        if (!less_q) begin
          key_d  = right_key_i;
          year_d = right_year_i;
        end
      end
      default: begin
        key_d  = key_q;
        year_d = year_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= 1'b0;
      eq_q   <= 1'b0;
    end else begin
      less_q <= less_d;
      eq_q   <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    year_q <= year_d;
  end

  assign key_o  = key_q;
  assign year_o = year_q;
  assign less_o = less_q;
  assign eq_o   = eq_q;

endmodule

>>> hw/rtl/sorted_key_table.sv
// Top level of the sorted key table: a chain of record cells with its sequencer.
//
// The table keeps up to CAPACITY records in ascending key order in a chain of
// cells, one record per cell. A request goes through a compare state and then
// an update state: in the compare state every cell compares its key with the
// request key, and in the update state the cells shift by one place for an
// insert or a remove while the result register loads. The next request is
// accepted in the update state. A result that is not taken holds the following
// request in its update state until the result register frees up.
// The table is empty after reset and needs no clearing pass.
module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  skt_req_if.sink      req_i,
  skt_rsp_if.source    rsp_o
);
  import skt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  fsm_e state_q, state_d;

  req_type_e               req_type_q;
  logic signed [KEY_W-1:0] req_key_q;
  logic [YEAR_W-1:0]       req_year_q;

  logic [CNT_W-1:0] count_q, count_d;

  logic                    rsp_valid_q, rsp_valid_d;
  status_e                 rsp_status_q, rsp_status_d;
  logic [YEAR_W-1:0]       rsp_year_q, rsp_year_d;
  logic [RANK_W-1:0]       rsp_rank_q, rsp_rank_d;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [YEAR_W-1:0]       cell_year [CAPACITY];
  logic [CAPACITY-1:0]     cell_less;
  logic [CAPACITY-1:0]     cell_eq;
  cell_ctrl_t              ctrl;

  logic              out_free;
  logic              accept;
  logic              fire;
  logic              hit;
  logic              full;
  logic [YEAR_W-1:0] hit_year;
  logic [RANK_W-1:0] hit_rank;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign fire     = (state_q == FSM_UPD) && out_free;
  assign accept   = req_i.valid && req_i.ready;
  assign hit      = |cell_eq;
  assign full     = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    hit_year = '0;
    hit_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_eq[i]) begin
        hit_year = hit_year | cell_year[i];
        hit_rank = hit_rank | RANK_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.op     = OP_HOLD;
    case (state_q)
      FSM_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = FSM_CMP;
        end
      end
      FSM_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = FSM_UPD;
      end
      FSM_UPD: begin
        if (out_free) begin
          req_i.ready = 1'b1;
          if (req_type_q == REQ_INSERT && !hit && !full) begin
            ctrl.op = OP_INSERT;
          end else if (req_type_q == REQ_REMOVE && hit) begin
            ctrl.op = OP_REMOVE;
          end
          state_d = req_i.valid ? FSM_CMP : FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    case (ctrl.op)
      OP_INSERT: count_d = count_q + CNT_W'(1);
      OP_REMOVE: count_d = count_q - CNT_W'(1);
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_year_d   = rsp_year_q;
    rsp_rank_d   = rsp_rank_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (fire) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = ST_OK;
      rsp_year_d   = '0;
      rsp_rank_d   = '0;
      case (req_type_q)
        REQ_INSERT: begin
          if (hit) begin
            rsp_status_d = ST_DUP;
          end else if (full) begin
            rsp_status_d = ST_FULL;
          end
        end
        REQ_LOOKUP: begin
          if (hit) begin
            rsp_year_d = hit_year;
          end else begin
            rsp_status_d = ST_MISSING;
          end
        end
        REQ_RANK: begin
          if (hit) begin
            rsp_rank_d = hit_rank;
          end else begin
            rsp_status_d = ST_MISSING;
          end
        end
        default: begin
          if (!hit) begin
            rsp_status_d = ST_MISSING;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_i.req_type;
      req_key_q  <= req_i.key;
      req_year_q <= req_i.year_in;
    end
    rsp_status_q <= rsp_status_d;
    rsp_year_q   <= rsp_year_d;
    rsp_rank_q   <= rsp_rank_d;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    prev_less;
    logic signed [KEY_W-1:0] left_key;
    logic [YEAR_W-1:0]       left_year;
    logic signed [KEY_W-1:0] right_key;
    logic [YEAR_W-1:0]       right_year;

    if (g == 0) begin : g_first
      assign prev_less = 1'b1;
      assign left_key  = req_key_q;
      assign left_year = req_year_q;
    end else begin : g_mid
      assign prev_less = cell_less[g-1];
      assign left_key  = cell_key[g-1];
      assign left_year = cell_year[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key  = cell_key[g];
      assign right_year = cell_year[g];
    end else begin : g_inner
      assign right_key  = cell_key[g+1];
      assign right_year = cell_year[g+1];
    end

    skt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occ_i        (CNT_W'(g) < count_q),
      .prev_less_i  (prev_less),
      .req_key_i    (req_key_q),
      .req_year_i   (req_year_q),
      .left_key_i   (left_key),
      .left_year_i  (left_year),
      .right_key_i  (right_key),
      .right_year_i (right_year),
      .key_o        (cell_key[g]),
      .year_o       (cell_year[g]),
      .less_o       (cell_less[g]),
      .eq_o         (cell_eq[g])
    );
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.year_out = rsp_year_q;
  assign rsp_o.rank     = rsp_rank_q;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the sorted key table: random and directed requests.
package skt_check_pkg;
  import skt_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [YEAR_W-1:0]   year_out;
    logic [RANK_W-1:0]   rank;
  } table_result_t;

  class shadow_key_table #(int CAP = 64);
    logic signed [KEY_W-1:0] keys [CAP];
    logic [YEAR_W-1:0]       years [CAP];
    int                      fill;
    table_result_t           pending_results [$];
    int                      bad_results;

    function new();
      fill = 0;
      bad_results = 0;
    endfunction

    function table_result_t apply_to_table(req_type_e kind, logic signed [KEY_W-1:0] key,
                                           logic [YEAR_W-1:0] year);
      table_result_t res;
      int            pos;
      bit            hit;
      res.status   = ST_OK;
      res.year_out = '0;
      res.rank     = '0;
      pos = 0;
      while (pos < fill && keys[pos] < key) pos++;
      hit = (pos < fill) && (keys[pos] == key);
      case (kind)
        REQ_INSERT: begin
          if (hit) begin
            res.status = ST_DUP;
          end else if (fill >= CAP) begin
            res.status = ST_FULL;
          end else begin
            for (int i = fill; i > pos; i--) begin
              keys[i]  = keys[i-1];
              years[i] = years[i-1];
            end
            keys[pos]  = key;
            years[pos] = year;
            fill++;
          end
        end
        REQ_LOOKUP: begin
          if (hit) res.year_out = years[pos];
          else res.status = ST_MISSING;
        end
        REQ_RANK: begin
          if (hit) res.rank = RANK_W'(pos + 1);
          else res.status = ST_MISSING;
        end
        default: begin
          if (hit) begin
            for (int i = pos; i < fill - 1; i++) begin
              keys[i]  = keys[i+1];
              years[i] = years[i+1];
            end
            fill--;
          end else begin
            res.status = ST_MISSING;
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(req_type_e kind, logic signed [KEY_W-1:0] key,
                               logic [YEAR_W-1:0] year);
      pending_results.push_back(apply_to_table(kind, key, year));
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("Result with no request outstanding: status %s year %0d rank %0d",
                   got.status.name(), got.year_out, got.rank);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.year_out !== want.year_out ||
          got.rank !== want.rank) begin
        bad_results++;
        if (bad_results <= 10)
          $display("Mismatch: expected status %s year %0d rank %0d, got status %s year %0d rank %0d",
                   want.status.name(), want.year_out, want.rank,
                   got.status.name(), got.year_out, got.rank);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass
endpackage

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;
  import skt_check_pkg::*;

  localparam int CAPACITY = 64;
  localparam int RANDOM_ITEMS = 1230;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni;

  skt_req_if req_if ();
  skt_rsp_if rsp_if ();

  shadow_key_table #(.CAP(CAPACITY)) table_check;

  int requests_taken = 0;
  int idle_cycles = 0;
  bit holding_off = 1'b0;
  bit hold_done = 1'b0;

  sorted_key_table #(.CAPACITY(CAPACITY)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    table_result_t got;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        table_check.note_request(req_if.req_type, req_if.key, req_if.year_in);
        requests_taken++;
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.status   = rsp_if.status;
        got.year_out = rsp_if.year_out;
        got.rank     = rsp_if.rank;
        table_check.check_result(got);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [7:0] stall_pattern;
    int         mode;
    int         span;
    int         phase;
    stall_pattern = 8'b1011_0110;
    phase = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && requests_taken >= 500 && requests_taken < 600) begin
        // The result register fills up and the block must stall its request side meanwhile.
        holding_off = 1'b1;
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        holding_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= 1'($urandom_range(0, 1));
          2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            rsp_if.ready <= stall_pattern[phase];
            phase = (phase + 1) % 8;
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_request(input req_type_e kind, input logic signed [KEY_W-1:0] key,
                              input logic [YEAR_W-1:0] year);
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.key      <= key;
    req_if.year_in  <= year;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key(input int hit_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < hit_pct && table_check.fill > 0)
      return table_check.keys[$urandom_range(0, table_check.fill - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 3) return int'($urandom_range(0, 15)) - 8;
    if (roll == 3) return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    return $urandom;
  endfunction

  task automatic random_request(input bit growing);
    int        roll;
    int        hit_pct;
    req_type_e kind;
    roll = $urandom_range(0, 99);
    if (growing)
      kind = roll < 65 ? REQ_INSERT : roll < 75 ? REQ_LOOKUP : roll < 90 ? REQ_RANK : REQ_REMOVE;
    else
      kind = roll < 8 ? REQ_INSERT : roll < 18 ? REQ_LOOKUP : roll < 28 ? REQ_RANK : REQ_REMOVE;
    hit_pct = (kind == REQ_INSERT) ? 20 : (kind == REQ_REMOVE) ? 85 : 55;
    send_request(kind, pick_key(hit_pct), 16'($urandom));
  endtask

  initial begin
    int burst;
    int gap;
    int full_items;
    bit growing;
    table_check = new();
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_INSERT;
    req_if.key = '0;
    req_if.year_in = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(REQ_LOOKUP, 0, 16'h0001);
    send_request(REQ_RANK, 0, 16'h0000);
    send_request(REQ_REMOVE, 5, 16'hffff);
    send_request(REQ_INSERT, KEY_MIN, 16'h0000);
    send_request(REQ_INSERT, KEY_MAX, 16'hffff);
    send_request(REQ_INSERT, 0, 16'h1234);
    send_request(REQ_INSERT, -1, 16'habcd);
    send_request(REQ_INSERT, 0, 16'h5555);
    send_request(REQ_LOOKUP, KEY_MIN, 16'hffff);
    send_request(REQ_LOOKUP, KEY_MAX, 16'h0000);
    send_request(REQ_RANK, KEY_MIN, 16'h0000);
    send_request(REQ_RANK, KEY_MAX, 16'h0000);
    send_request(REQ_RANK, -1, 16'h0000);
    send_request(REQ_LOOKUP, 7, 16'h0000);
    send_request(REQ_RANK, 1, 16'h0000);
    send_request(REQ_REMOVE, -1, 16'h0000);
    send_request(REQ_RANK, 0, 16'h0000);
    send_request(REQ_REMOVE, 3, 16'h0000);
    send_request(REQ_REMOVE, KEY_MIN, 16'h0000);
    send_request(REQ_REMOVE, KEY_MAX, 16'h0000);
    send_request(REQ_REMOVE, 0, 16'h0000);
    send_request(REQ_LOOKUP, 0, 16'h0000);

    // The table is filled to capacity and drained again several times over.
    burst = 0;
    full_items = 0;
    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = (holding_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst--;
      if (growing && table_check.fill >= CAPACITY) begin
        full_items++;
        if (full_items > 12) begin
          growing = 1'b0;
          full_items = 0;
        end
      end
      if (!growing && table_check.fill == 0) growing = 1'b1;
      random_request(growing);
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (table_check.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (table_check.bad_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_if.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table.sv
verif/tb.sv
